>>> design/nrag_pkg.sv
// Shared types and constants for the nearest-neighbor resize address generator.
// No dependencies; imported by nrag_div and nearest_resize_address_gen_core.
package nrag_pkg;

    localparam int MODE_W  = 2;
    localparam int CH_W    = 16;
    localparam int OUTER_W = 30;
    localparam int INNER_W = 20;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE              = 3'd0,
        CFG_CHANNELS          = 3'd1,
        CFG_OUT_SIZES         = 3'd2,
        CFG_IN_SIZES          = 3'd3,
        CFG_SRC_STRIDES_OUTER = 3'd4,
        CFG_SRC_STRIDES_INNER = 3'd5,
        CFG_DST_STRIDES_OUTER = 3'd6,
        CFG_DST_STRIDES_INNER = 3'd7
    } cfg_idx_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_1D   = 2'd0,
        MODE_2D   = 2'd1,
        MODE_3D   = 2'd2,
        MODE_NONE = 2'd3
    } mode_t;

endpackage

>>> design/nrag_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a sideband
// that travels alongside. Depends on nrag_pkg only by project convention.
module nrag_div #(
    parameter int NUM_W = 40,
    parameter int DEN_W = 16,
    parameter int SB_W  = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] in_num,
    input  logic [SB_W-1:0]  in_sb,
    input  logic [DEN_W-1:0] den,
    output logic             out_valid,
    output logic [NUM_W-1:0] out_quot,
    output logic [DEN_W-1:0] out_rem,
    output logic [SB_W-1:0]  out_sb
);
    import nrag_pkg::*;

    logic [NUM_W-1:0] vld_reg;
    logic [DEN_W-1:0] rem_reg [NUM_W];
    logic [NUM_W-1:0] nq_reg  [NUM_W];
    logic [SB_W-1:0]  sb_reg  [NUM_W];

    genvar i;
    generate
        for (i = 0; i < NUM_W; i++) begin : g_stage
            logic             prev_vld;
            logic [DEN_W-1:0] prev_rem;
            logic [NUM_W-1:0] prev_nq;
            logic [SB_W-1:0]  prev_sb;
            logic [DEN_W:0]   trial;
            logic [DEN_W:0]   diff;
            logic             ge;
            logic [DEN_W-1:0] rem_next;
            logic [NUM_W-1:0] nq_next;

            if (i == 0) begin : g_first
                assign prev_vld = in_valid;
                assign prev_rem = '0;
                assign prev_nq  = in_num;
                assign prev_sb  = in_sb;
            end else begin : g_rest
                assign prev_vld = vld_reg[i-1];
                assign prev_rem = rem_reg[i-1];
                assign prev_nq  = nq_reg[i-1];
                assign prev_sb  = sb_reg[i-1];
            end

            always_comb begin
                trial    = {prev_rem, prev_nq[NUM_W-1]};
                diff     = trial - {1'b0, den};
                ge       = (trial >= {1'b0, den});
                rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                nq_next  = {prev_nq[NUM_W-2:0], ge};
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[i] <= 1'b0;
                end else if (en) begin
                    vld_reg[i] <= prev_vld;
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[i] <= rem_next;
                    nq_reg[i]  <= nq_next;
                    sb_reg[i]  <= prev_sb;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[NUM_W-1];
    assign out_quot  = nq_reg[NUM_W-1];
    assign out_rem   = rem_reg[NUM_W-1];
    assign out_sb    = sb_reg[NUM_W-1];

endmodule

>>> design/nearest_resize_address_gen_core.sv
// Nearest-neighbor resize address generator: one request in, one offset pair out.
// Throughput: one request per cycle while the output is not stalled, no bubbles.
// The whole pipeline holds while the output register is full and not taken.
// Reset (aresetn, synchronous, active low) clears valid bits and loads register defaults.
// Depends on nrag_pkg and nrag_div.
module nearest_resize_address_gen_core #(
    parameter int COORD_BITS  = 16,
    parameter int INDEX_BITS  = 48,
    parameter int LINEAR_BITS = 40
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration write port
    input  logic                                  cfg_wr_en,
    input  logic [nrag_pkg::CFG_IDX_W-1:0]        cfg_wr_index,
    input  logic [((3*COORD_BITS > 60) ? 3*COORD_BITS : 60)-1:0] cfg_wr_data,
    // request channel
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [LINEAR_BITS-1:0]                s_element_index,
    // result channel
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [INDEX_BITS-1:0]                 m_source_index,
    output logic [INDEX_BITS-1:0]                 m_dest_index
);
    import nrag_pkg::*;

    localparam int SIZE_W = 3 * COORD_BITS;
    localparam int DPW    = COORD_BITS + INNER_W;
    localparam int CW     = CH_W + OUTER_W;
    // batch number is split in two halves so each stride product stays narrow
    localparam int BLO_W  = LINEAR_BITS / 2;
    localparam int BHI_W  = LINEAR_BITS - BLO_W;
    localparam int PLO_W  = BLO_W + OUTER_W;
    localparam int PHI_W  = BHI_W + OUTER_W;

    // ---------------- configuration registers ----------------
    logic [MODE_W-1:0]    mode_reg;
    logic [CH_W-1:0]      channels_reg;
    logic [SIZE_W-1:0]    out_sizes_reg;
    logic [SIZE_W-1:0]    in_sizes_reg;
    logic [2*OUTER_W-1:0] src_outer_reg;
    logic [3*INNER_W-1:0] src_inner_reg;
    logic [2*OUTER_W-1:0] dst_outer_reg;
    logic [3*INNER_W-1:0] dst_inner_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_1D;
            channels_reg  <= CH_W'(1);
            out_sizes_reg <= {3{COORD_BITS'(1)}};
            in_sizes_reg  <= {3{COORD_BITS'(1)}};
            src_outer_reg <= '0;
            src_inner_reg <= '0;
            dst_outer_reg <= '0;
            dst_inner_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_wr_index))
                CFG_MODE:              mode_reg      <= cfg_wr_data[MODE_W-1:0];
                CFG_CHANNELS:          channels_reg  <= cfg_wr_data[CH_W-1:0];
                CFG_OUT_SIZES:         out_sizes_reg <= cfg_wr_data[SIZE_W-1:0];
                CFG_IN_SIZES:          in_sizes_reg  <= cfg_wr_data[SIZE_W-1:0];
                CFG_SRC_STRIDES_OUTER: src_outer_reg <= cfg_wr_data[2*OUTER_W-1:0];
                CFG_SRC_STRIDES_INNER: src_inner_reg <= cfg_wr_data[3*INNER_W-1:0];
                CFG_DST_STRIDES_OUTER: dst_outer_reg <= cfg_wr_data[2*OUTER_W-1:0];
                CFG_DST_STRIDES_INNER: dst_inner_reg <= cfg_wr_data[3*INNER_W-1:0];
                default: ;
            endcase
        end
    end

    function automatic logic [COORD_BITS-1:0] size_field(
        input logic [SIZE_W-1:0] w, input logic [1:0] k);
        logic [COORD_BITS-1:0] r;
        unique case (k)
            2'd0:    r = w[0*COORD_BITS +: COORD_BITS];
            2'd1:    r = w[1*COORD_BITS +: COORD_BITS];
            2'd2:    r = w[2*COORD_BITS +: COORD_BITS];
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [INNER_W-1:0] stride_field(
        input logic [3*INNER_W-1:0] w, input logic [1:0] k);
        logic [INNER_W-1:0] r;
        unique case (k)
            2'd0:    r = w[0*INNER_W +: INNER_W];
            2'd1:    r = w[1*INNER_W +: INNER_W];
            2'd2:    r = w[2*INNER_W +: INNER_W];
            default: r = '0;
        endcase
        return r;
    endfunction

    // ---------------- pipeline control ----------------
    // Every stage moves together; hold everything while the output is full and stalled.
    logic out_valid_reg;
    logic advance;

    assign advance = !out_valid_reg || m_ready;
    assign s_ready = advance;

    // Per-slot links: index 0 is the request, index j+1 leaves spatial slot j.
    logic                   slot_valid [4];
    logic [LINEAR_BITS-1:0] slot_rest  [4];
    logic [INDEX_BITS-1:0]  slot_src   [4];
    logic [INDEX_BITS-1:0]  slot_dst   [4];

    assign slot_valid[0] = s_valid;
    assign slot_rest[0]  = s_element_index;
    assign slot_src[0]   = '0;
    assign slot_dst[0]   = '0;

    // ---------------- spatial slots ----------------
    // Slot 0 handles the innermost active axis. Slots beyond the active axis count
    // divide by one with zero strides, so they pass the index through untouched.
    genvar j;
    generate
        for (j = 0; j < 3; j++) begin : g_slot
            logic                    active;
            logic [1:0]              fsel;
            logic [COORD_BITS-1:0]   osz_raw;
            logic [COORD_BITS-1:0]   osz;
            logic [COORD_BITS-1:0]   isz;
            logic [INNER_W-1:0]      sstr;
            logic [INNER_W-1:0]      dstr;

            always_comb begin
                active  = (mode_reg != MODE_NONE) && (mode_reg >= 2'(j));
                fsel    = mode_reg - 2'(j);
                osz_raw = size_field(out_sizes_reg, fsel);
                osz     = (!active || osz_raw == '0) ? COORD_BITS'(1) : osz_raw;
                isz     = active ? size_field(in_sizes_reg, fsel) : '0;
                sstr    = active ? stride_field(src_inner_reg, fsel) : '0;
                dstr    = active ? stride_field(dst_inner_reg, fsel) : '0;
            end

            // rest / out_size -> next rest and coordinate
            logic                    a_valid;
            logic [LINEAR_BITS-1:0]  a_quot;
            logic [COORD_BITS-1:0]   a_rem;
            logic [2*INDEX_BITS-1:0] a_sb;

            nrag_div #(
                .NUM_W(LINEAR_BITS),
                .DEN_W(COORD_BITS),
                .SB_W (2*INDEX_BITS)
            ) u_div_rest (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .en       (advance),
                .in_valid (slot_valid[j]),
                .in_num   (slot_rest[j]),
                .in_sb    ({slot_src[j], slot_dst[j]}),
                .den      (osz),
                .out_valid(a_valid),
                .out_quot (a_quot),
                .out_rem  (a_rem),
                .out_sb   (a_sb)
            );

            // scale the coordinate by the input size; weight it by the destination stride
            logic                    p_valid_reg;
            logic [LINEAR_BITS-1:0]  p_rest_reg;
            logic [2*COORD_BITS-1:0] p_prod_reg;
            logic [INDEX_BITS-1:0]   p_dstp_reg;
            logic [INDEX_BITS-1:0]   p_src_reg;
            logic [INDEX_BITS-1:0]   p_dst_reg;

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    p_valid_reg <= 1'b0;
                end else if (advance) begin
                    p_valid_reg <= a_valid;
                end
            end

            always_ff @(posedge aclk) begin
                if (advance) begin
                    p_rest_reg <= a_quot;
                    p_prod_reg <= (2*COORD_BITS)'(a_rem) * (2*COORD_BITS)'(isz);
                    p_dstp_reg <= INDEX_BITS'(DPW'(a_rem) * DPW'(dstr));
                    p_src_reg  <= a_sb[2*INDEX_BITS-1:INDEX_BITS];
                    p_dst_reg  <= a_sb[INDEX_BITS-1:0];
                end
            end

            // coord*in_size / out_size -> source coordinate
            logic                                    b_valid;
            logic [2*COORD_BITS-1:0]                 b_quot;
            logic [COORD_BITS-1:0]                   b_rem;
            logic [LINEAR_BITS+2*INDEX_BITS-1:0]     b_sb;

            nrag_div #(
                .NUM_W(2*COORD_BITS),
                .DEN_W(COORD_BITS),
                .SB_W (LINEAR_BITS + 2*INDEX_BITS)
            ) u_div_map (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .en       (advance),
                .in_valid (p_valid_reg),
                .in_num   (p_prod_reg),
                .in_sb    ({p_rest_reg, p_src_reg, p_dst_reg + p_dstp_reg}),
                .den      (osz),
                .out_valid(b_valid),
                .out_quot (b_quot),
                .out_rem  (b_rem),
                .out_sb   (b_sb)
            );

            // clamp to in_size-1 (zero when in_size is zero) and weight by source stride
            logic [COORD_BITS-1:0] mapped;
            logic                  unused_rem;

            assign unused_rem = ^b_rem;

            always_comb begin
                if (isz == '0) begin
                    mapped = '0;
                end else if (b_quot > (2*COORD_BITS)'(isz) - (2*COORD_BITS)'(1)) begin
                    mapped = isz - COORD_BITS'(1);
                end else begin
                    mapped = b_quot[COORD_BITS-1:0];
                end
            end

            logic                   m_valid_reg;
            logic [LINEAR_BITS-1:0] m_rest_reg;
            logic [INDEX_BITS-1:0]  m_src_reg;
            logic [INDEX_BITS-1:0]  m_dst_reg;
            logic [INDEX_BITS-1:0]  m_srcp_reg;

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    m_valid_reg <= 1'b0;
                end else if (advance) begin
                    m_valid_reg <= b_valid;
                end
            end

            always_ff @(posedge aclk) begin
                if (advance) begin
                    m_rest_reg <= b_sb[LINEAR_BITS+2*INDEX_BITS-1:2*INDEX_BITS];
                    m_src_reg  <= b_sb[2*INDEX_BITS-1:INDEX_BITS];
                    m_dst_reg  <= b_sb[INDEX_BITS-1:0];
                    m_srcp_reg <= INDEX_BITS'(DPW'(mapped) * DPW'(sstr));
                end
            end

            assign slot_valid[j+1] = m_valid_reg;
            assign slot_rest[j+1]  = m_rest_reg;
            assign slot_src[j+1]   = m_src_reg + m_srcp_reg;
            assign slot_dst[j+1]   = m_dst_reg;
        end
    endgenerate

    // ---------------- batch / channel split ----------------
    logic [CH_W-1:0] ch_den;
    assign ch_den = (channels_reg == '0) ? CH_W'(1) : channels_reg;

    logic                    c_valid;
    logic [LINEAR_BITS-1:0]  c_batch;
    logic [CH_W-1:0]         c_chan;
    logic [2*INDEX_BITS-1:0] c_sb;

    nrag_div #(
        .NUM_W(LINEAR_BITS),
        .DEN_W(CH_W),
        .SB_W (2*INDEX_BITS)
    ) u_div_chan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (advance),
        .in_valid (slot_valid[3]),
        .in_num   (slot_rest[3]),
        .in_sb    ({slot_src[3], slot_dst[3]}),
        .den      (ch_den),
        .out_valid(c_valid),
        .out_quot (c_batch),
        .out_rem  (c_chan),
        .out_sb   (c_sb)
    );

    // weight batch and channel by the outer strides; batch goes as two half products
    logic                  q_valid_reg;
    logic [INDEX_BITS-1:0] q_src_reg;
    logic [INDEX_BITS-1:0] q_dst_reg;
    logic [INDEX_BITS-1:0] q_sbl_reg;
    logic [INDEX_BITS-1:0] q_sbh_reg;
    logic [INDEX_BITS-1:0] q_sc_reg;
    logic [INDEX_BITS-1:0] q_dbl_reg;
    logic [INDEX_BITS-1:0] q_dbh_reg;
    logic [INDEX_BITS-1:0] q_dc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_valid_reg <= 1'b0;
        end else if (advance) begin
            q_valid_reg <= c_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            q_src_reg <= c_sb[2*INDEX_BITS-1:INDEX_BITS];
            q_dst_reg <= c_sb[INDEX_BITS-1:0];
            q_sbl_reg <= INDEX_BITS'(PLO_W'(c_batch[BLO_W-1:0])
                                     * PLO_W'(src_outer_reg[OUTER_W-1:0]));
            q_sbh_reg <= INDEX_BITS'(PHI_W'(c_batch[LINEAR_BITS-1:BLO_W])
                                     * PHI_W'(src_outer_reg[OUTER_W-1:0]));
            q_sc_reg  <= INDEX_BITS'(CW'(c_chan) * CW'(src_outer_reg[2*OUTER_W-1:OUTER_W]));
            q_dbl_reg <= INDEX_BITS'(PLO_W'(c_batch[BLO_W-1:0])
                                     * PLO_W'(dst_outer_reg[OUTER_W-1:0]));
            q_dbh_reg <= INDEX_BITS'(PHI_W'(c_batch[LINEAR_BITS-1:BLO_W])
                                     * PHI_W'(dst_outer_reg[OUTER_W-1:0]));
            q_dc_reg  <= INDEX_BITS'(CW'(c_chan) * CW'(dst_outer_reg[2*OUTER_W-1:OUTER_W]));
        end
    end

    // ---------------- output register ----------------
    // Final sums wrap to INDEX_BITS; the undefined mode drives both offsets to zero.
    logic [INDEX_BITS-1:0] src_out_reg;
    logic [INDEX_BITS-1:0] dst_out_reg;
    logic [INDEX_BITS-1:0] src_out_next;
    logic [INDEX_BITS-1:0] dst_out_next;

    always_comb begin
        if (mode_reg == MODE_NONE) begin
            src_out_next = '0;
            dst_out_next = '0;
        end else begin
            src_out_next = q_src_reg + q_sbl_reg + (q_sbh_reg << BLO_W) + q_sc_reg;
            dst_out_next = q_dst_reg + q_dbl_reg + (q_dbh_reg << BLO_W) + q_dc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= q_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            src_out_reg <= src_out_next;
            dst_out_reg <= dst_out_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_source_index = src_out_reg;
    assign m_dest_index   = dst_out_reg;

endmodule
